@@ rtl/mss_pkg.sv @@
// Shared types, constants and helper functions for the muscle signal synthesizer.
// No dependencies; every other file imports this package.
package mss_pkg;

   localparam int unsigned ENV_W    = 11;
   localparam int unsigned FAT_W    = 10;
   localparam int unsigned PHASE_W  = 16;
   localparam int unsigned HOLD_W   = 16;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned NOISE_W  = 32;
   localparam int unsigned CSR_W    = 16;
   localparam int unsigned MUL_A_W  = 18;
   localparam int unsigned MUL_B_W  = 14;
   localparam int unsigned PROD_W   = 32;
   localparam int unsigned WGT_W    = 10;

   localparam logic [ENV_W-1:0]   ENV_FULL       = 11'd1024;
   localparam logic [ENV_W-1:0]   ENV_TOP        = 11'd1012;
   localparam logic [3:0]         FATIGUE_TICKS  = 4'd8;
   localparam logic [3:0]         RECOVERY_TICKS = 4'd12;
   localparam logic [NOISE_W-1:0] NOISE_SEED     = 32'h1f2e3d4c;
   localparam logic [PHASE_W-1:0] STEP_SLOW      = 16'd1278;
   localparam logic [PHASE_W-1:0] STEP_MEDIUM    = 16'd2687;
   localparam logic [PHASE_W-1:0] STEP_FAST      = 16'd4489;
   localparam logic [WGT_W-1:0]   W_SLOW_BASE    = 10'd520;
   localparam logic [WGT_W-1:0]   W_FAST_BASE    = 10'd560;
   localparam logic [WGT_W-1:0]   W_FAST_MIN     = 10'd150;
   localparam logic signed [MUL_B_W-1:0] W_MEDIUM = 14'sd680;
   localparam logic signed [MUL_B_W-1:0] W_NOISE  = 14'sd220;

   typedef enum logic [2:0] {
      CSR_REST_LEVEL    = 3'd0,
      CSR_ATTACK_STEP   = 3'd1,
      CSR_FAST_FALL     = 3'd2,
      CSR_BRAKED_FALL   = 3'd3,
      CSR_HOLD_LIMIT    = 3'd4,
      CSR_FATIGUE_LIMIT = 3'd5,
      CSR_OUTPUT_GAIN   = 3'd6,
      CSR_OUTPUT_LIMIT  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CH0 = 2'd0,
      CH1 = 2'd1,
      CH2 = 2'd2
   } chan_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREP,
      BK_MAC,
      BK_SCALE,
      BK_SAT,
      BK_SEND
   } bk_state_type;

   typedef struct packed {
      logic lift;
      logic brake;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_ch0;
      logic signed [SAMPLE_W-1:0] sample_ch1;
      logic signed [SAMPLE_W-1:0] sample_ch2;
   } rsp_type;

   typedef struct packed {
      logic [ENV_W-1:0]  rest_level;
      logic [ENV_W-1:0]  attack_step;
      logic [ENV_W-1:0]  fast_fall_step;
      logic [ENV_W-1:0]  braked_fall_step;
      logic [HOLD_W-1:0] hold_limit;
      logic [FAT_W-1:0]  fatigue_limit;
      logic [12:0]       output_gain_q10;
      logic [14:0]       output_limit;
   } cfg_type;

   // one movement snapshot handed from front to back
   typedef struct packed {
      logic [ENV_W-1:0]   envelope;
      logic [FAT_W-1:0]   fatigue_level;
      logic [PHASE_W-1:0] phase_slow;
      logic [PHASE_W-1:0] phase_medium;
      logic [PHASE_W-1:0] phase_fast;
   } qe_type;

   function automatic logic [PHASE_W-1:0] chan_offset(input logic [1:0] ch);
      logic [PHASE_W-1:0] off;
      case (ch)
         CH1:     off = 16'h1555;
         CH2:     off = 16'h2aaa;
         default: off = 16'h0000;
      endcase
      return off;
   endfunction

   function automatic logic signed [MUL_B_W-1:0] chan_gain(input logic [1:0] ch);
      logic signed [MUL_B_W-1:0] g;
      case (ch)
         CH1:     g = 14'sd740;
         CH2:     g = 14'sd560;
         default: g = 14'sd1024;
      endcase
      return g;
   endfunction

   // fold the phase, keep 11 bits, recenter by flipping the top bit
   function automatic logic signed [10:0] triangle(input logic [PHASE_W-1:0] p);
      logic [PHASE_W-1:0] folded;
      folded = p[15] ? ~p : p;
      return {~folded[14], folded[13:4]};
   endfunction

   function automatic logic [NOISE_W-1:0] noise_next(input logic [NOISE_W-1:0] x);
      logic [NOISE_W-1:0] t;
      t = x ^ (x << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return t;
   endfunction

endpackage

@@ rtl/mss_front.sv @@
// Front end: accepts lift/brake requests and advances the movement state.
// Pushes one snapshot per request into the queue. Depends on mss_pkg.
module mss_front import mss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   input  logic    q_full,
   output logic    q_push,
   output qe_type  q_data
);

   logic [ENV_W-1:0]   env_ff, env_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic [FAT_W-1:0]   fat_ff, fat_in;
   logic [2:0]         fdiv_ff, fdiv_in;
   logic [3:0]         rdiv_ff, rdiv_in;
   logic [PHASE_W-1:0] ph_slow_ff, ph_slow_in;
   logic [PHASE_W-1:0] ph_med_ff, ph_med_in;
   logic [PHASE_W-1:0] ph_fast_ff, ph_fast_in;

   logic              accept;
   logic [ENV_W:0]    env_sum;
   logic [ENV_W-1:0]  env_up;
   logic [HOLD_W-1:0] hold_up;
   logic [3:0]        fdiv_inc;
   logic [3:0]        rdiv_inc;
   logic [ENV_W-1:0]  fall_step;
   logic [ENV_W-1:0]  gap;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;
   assign q_data    = '{envelope:      env_in,
                        fatigue_level: fat_in,
                        phase_slow:    ph_slow_in,
                        phase_medium:  ph_med_in,
                        phase_fast:    ph_fast_in};

   assign env_sum   = {1'b0, env_ff} + {1'b0, cfg.attack_step};
   assign fdiv_inc  = {1'b0, fdiv_ff} + 4'd1;
   assign rdiv_inc  = rdiv_ff + 4'd1;
   assign fall_step = req_data.brake ? cfg.braked_fall_step : cfg.fast_fall_step;
   assign gap       = env_ff - cfg.rest_level;

   always_comb begin
      env_up = env_ff;
      if (env_ff < ENV_FULL) begin
         env_up = (env_sum > {1'b0, ENV_FULL}) ? ENV_FULL : env_sum[ENV_W-1:0];
      end
      hold_up = (hold_ff != '1) ? hold_ff + 16'd1 : hold_ff;
   end

   always_comb begin
      env_in     = env_ff;
      hold_in    = hold_ff;
      fat_in     = fat_ff;
      fdiv_in    = fdiv_ff;
      rdiv_in    = rdiv_ff;
      ph_slow_in = ph_slow_ff;
      ph_med_in  = ph_med_ff;
      ph_fast_in = ph_fast_ff;
      if (accept) begin
         if (req_data.lift) begin
            env_in = env_up;
            if (env_up >= ENV_TOP) begin
               hold_in = hold_up;
               if (hold_up > cfg.hold_limit) begin
                  if (fdiv_inc >= FATIGUE_TICKS) begin
                     fdiv_in = 3'd0;
                     if (fat_ff < cfg.fatigue_limit) begin
                        fat_in = fat_ff + 10'd1;
                     end
                  end else begin
                     fdiv_in = fdiv_inc[2:0];
                  end
               end
            end else begin
               hold_in = '0;
               fdiv_in = '0;
            end
         end else begin
            hold_in = '0;
            fdiv_in = '0;
            if (env_ff > cfg.rest_level) begin
               env_in = env_ff - ((gap < fall_step) ? gap : fall_step);
            end else begin
               env_in = cfg.rest_level;
            end
            if (fat_ff != '0) begin
               if (rdiv_inc >= RECOVERY_TICKS) begin
                  rdiv_in = 4'd0;
                  fat_in  = fat_ff - 10'd1;
               end else begin
                  rdiv_in = rdiv_inc;
               end
            end
         end
         ph_slow_in = ph_slow_ff + STEP_SLOW;
         ph_med_in  = ph_med_ff + STEP_MEDIUM;
         ph_fast_in = ph_fast_ff + STEP_FAST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff     <= 11'd42;
         hold_ff    <= '0;
         fat_ff     <= '0;
         fdiv_ff    <= '0;
         rdiv_ff    <= '0;
         ph_slow_ff <= '0;
         ph_med_ff  <= '0;
         ph_fast_ff <= '0;
      end else begin
         env_ff     <= env_in;
         hold_ff    <= hold_in;
         fat_ff     <= fat_in;
         fdiv_ff    <= fdiv_in;
         rdiv_ff    <= rdiv_in;
         ph_slow_ff <= ph_slow_in;
         ph_med_ff  <= ph_med_in;
         ph_fast_ff <= ph_fast_in;
      end
   end

endmodule

@@ rtl/mss_queue.sv @@
// Small FIFO of movement snapshots between front and back end.
// Depends on mss_pkg for the entry type.
module mss_queue import mss_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  qe_type push_data,
   output logic   full,
   input  logic   pop,
   output qe_type pop_data,
   output logic   empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   qe_type        mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/mss_back.sv @@
// Back end: turns each movement snapshot into three saturated samples using
// one shared 18x14 multiplier and owns the noise generator. Depends on mss_pkg.
module mss_back import mss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_empty,
   input  qe_type  q_data,
   output logic    q_pop,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   bk_state_type state_ff, state_in;
   logic [1:0]   ch_ff, ch_in;
   logic [1:0]   step_ff, step_in;
   qe_type       entry_ff, entry_in;
   logic [NOISE_W-1:0] noise_ff, noise_in;

   logic signed [10:0]       tri_lo_ff, tri_mid_ff, tri_hi_ff;
   logic signed [10:0]       tri_lo_in, tri_mid_in, tri_hi_in;
   logic signed [9:0]        nz_ff, nz_in;
   logic [WGT_W-1:0]         w_lo_ff, w_lo_in, w_hi_ff, w_hi_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SAMPLE_W-1:0] smp_ff [3];
   logic signed [SAMPLE_W-1:0] smp_in [3];
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [PROD_W-1:0]  acc_sh;
   logic signed [PROD_W-1:0]  prod_sh;
   logic signed [21:0]        sat_val;
   logic signed [21:0]        lim_pos;
   logic signed [21:0]        lim_neg;
   logic signed [SAMPLE_W-1:0] sat_out;
   logic [PHASE_W-1:0] off;
   logic [NOISE_W-1:0] noise_nx;
   logic [WGT_W-1:0]   w_hi_raw;
   logic               out_free;

   assign mul_p     = mul_a * mul_b;
   assign acc_sh    = acc_ff >>> 8;
   assign prod_sh   = prod_ff >>> 10;
   assign sat_val   = prod_sh[21:0];
   assign lim_pos   = $signed({7'd0, cfg.output_limit});
   assign lim_neg   = -lim_pos;
   assign off       = chan_offset(ch_ff);
   assign noise_nx  = noise_next(noise_ff);
   assign w_hi_raw  = W_FAST_BASE - {1'b0, entry_ff.fatigue_level[9:1]};
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign q_pop     = (state_ff == BK_IDLE) && !q_empty;

   always_comb begin
      if (sat_val > lim_pos) begin
         sat_out = lim_pos[SAMPLE_W-1:0];
      end else if (sat_val < lim_neg) begin
         sat_out = lim_neg[SAMPLE_W-1:0];
      end else begin
         sat_out = sat_val[SAMPLE_W-1:0];
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == BK_MAC) begin
         case (step_ff)
            2'd0: begin
               mul_a = {{7{tri_lo_ff[10]}}, tri_lo_ff};
               mul_b = {4'd0, w_lo_ff};
            end
            2'd1: begin
               mul_a = {{7{tri_mid_ff[10]}}, tri_mid_ff};
               mul_b = W_MEDIUM;
            end
            2'd2: begin
               mul_a = {{7{tri_hi_ff[10]}}, tri_hi_ff};
               mul_b = {4'd0, w_hi_ff};
            end
            default: begin
               mul_a = {{8{nz_ff[9]}}, nz_ff};
               mul_b = W_NOISE;
            end
         endcase
      end else if (state_ff == BK_SCALE) begin
         case (step_ff)
            2'd0: begin
               mul_a = acc_sh[MUL_A_W-1:0];
               mul_b = {3'd0, entry_ff.envelope};
            end
            2'd1: begin
               mul_a = prod_sh[MUL_A_W-1:0];
               mul_b = chan_gain(ch_ff);
            end
            default: begin
               mul_a = prod_sh[MUL_A_W-1:0];
               mul_b = {1'b0, cfg.output_gain_q10};
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      step_in      = step_ff;
      entry_in     = entry_ff;
      noise_in     = noise_ff;
      tri_lo_in    = tri_lo_ff;
      tri_mid_in   = tri_mid_ff;
      tri_hi_in    = tri_hi_ff;
      nz_in        = nz_ff;
      w_lo_in      = w_lo_ff;
      w_hi_in      = w_hi_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      smp_in       = smp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               entry_in = q_data;
               ch_in    = CH0;
               state_in = BK_PREP;
            end
         end
         BK_PREP: begin
            tri_lo_in  = triangle(entry_ff.phase_slow + off);
            tri_mid_in = triangle(entry_ff.phase_medium + {1'b0, off[15:1]});
            tri_hi_in  = triangle(entry_ff.phase_fast + {off[14:0], 1'b0});
            noise_in   = noise_nx;
            nz_in      = {~noise_nx[31], noise_nx[30:22]};
            w_lo_in    = W_SLOW_BASE + {2'd0, entry_ff.fatigue_level[9:2]};
            w_hi_in    = (w_hi_raw < W_FAST_MIN) ? W_FAST_MIN : w_hi_raw;
            acc_in     = '0;
            step_in    = 2'd0;
            state_in   = BK_MAC;
         end
         BK_MAC: begin
            acc_in  = acc_ff + mul_p;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               step_in  = 2'd0;
               state_in = BK_SCALE;
            end
         end
         BK_SCALE: begin
            prod_in = mul_p;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               step_in  = 2'd0;
               state_in = BK_SAT;
            end
         end
         BK_SAT: begin
            smp_in[ch_ff] = sat_out;
            if (ch_ff == CH2) begin
               state_in = BK_SEND;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = BK_PREP;
            end
         end
         BK_SEND: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{sample_ch0: smp_ff[0],
                                sample_ch1: smp_ff[1],
                                sample_ch2: smp_ff[2]};
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      tri_lo_ff   <= tri_lo_in;
      tri_mid_ff  <= tri_mid_in;
      tri_hi_ff   <= tri_hi_in;
      nz_ff       <= nz_in;
      w_lo_ff     <= w_lo_in;
      w_hi_ff     <= w_hi_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      smp_ff      <= smp_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ch_ff        <= CH0;
         step_ff      <= '0;
         noise_ff     <= NOISE_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
         noise_ff     <= noise_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/muscle_signal_synthesizer.sv @@
// Simulated three-channel muscle signal source: one lift/brake request in,
// three saturated 16-bit samples out per request. Built on mss_pkg and its submodules.
// Usage:
//   req_valid/req_data/req_stall carry one movement tick (lift, brake). A
//   request is taken at a clock edge with req_valid high and req_stall low.
//   rsp_valid/rsp_data/rsp_stall return one result per request, in order.
//   csr_we/csr_index/csr_wdata write the eight control registers; write them
//   only while no request is in flight.
// Sequencing:
//   The front end updates the envelope, fatigue and phases in the cycle the
//   request is taken and queues the snapshot. The back end works through
//   the three channels in turn on one shared 18x14 multiplier (four weighted
//   terms, envelope, channel and output gain, saturation), after picking up
//   the snapshot and before handing off the result. It takes a new snapshot
//   only once the last result has been handed off.
// Reset and stall:
//   Synchronous reset restores the register defaults, the movement state and
//   the noise seed, and empties the queue and output register. While
//   rsp_stall is high the result holds; the back end finishes the next item
//   and the queue absorbs further requests before req_stall rises.
module muscle_signal_synthesizer import mss_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_type          req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             rsp_stall,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    q_push, q_pop, q_full, q_empty;
   qe_type  q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rest_level       <= 11'd42;
         cfg_ff.attack_step      <= 11'd1;
         cfg_ff.fast_fall_step   <= 11'd13;
         cfg_ff.braked_fall_step <= 11'd5;
         cfg_ff.hold_limit       <= 16'd1000;
         cfg_ff.fatigue_limit    <= 10'd768;
         cfg_ff.output_gain_q10  <= 13'd3072;
         cfg_ff.output_limit     <= 15'd22000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REST_LEVEL:    cfg_ff.rest_level       <= csr_wdata[10:0];
            CSR_ATTACK_STEP:   cfg_ff.attack_step      <= csr_wdata[10:0];
            CSR_FAST_FALL:     cfg_ff.fast_fall_step   <= csr_wdata[10:0];
            CSR_BRAKED_FALL:   cfg_ff.braked_fall_step <= csr_wdata[10:0];
            CSR_HOLD_LIMIT:    cfg_ff.hold_limit       <= csr_wdata[15:0];
            CSR_FATIGUE_LIMIT: cfg_ff.fatigue_limit    <= csr_wdata[9:0];
            CSR_OUTPUT_GAIN:   cfg_ff.output_gain_q10  <= csr_wdata[12:0];
            CSR_OUTPUT_LIMIT:  cfg_ff.output_limit     <= csr_wdata[14:0];
            default:           cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   mss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   mss_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   mss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
